### src/kwise_polynomial_hash_generator_assert.svh
// assertion macros for the polynomial hash block
`ifndef KWISE_POLYNOMIAL_HASH_GENERATOR_ASSERT_SVH
`define KWISE_POLYNOMIAL_HASH_GENERATOR_ASSERT_SVH

// same-cycle implication
`define KPH_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KPH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/kph_pkg.sv
`default_nettype none
package kph_pkg;

   localparam int MAX_TERMS  = 6;
   localparam int VAL_W      = 63;
   localparam int HALF_W     = 32;
   localparam int TERM_W     = 3;
   localparam int VBITS_W    = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VALUE_BITS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TERM_COUNT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_FIRST = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_LAST  = 4'd7;

   // item kinds
   localparam logic [1:0] FUNC_NEXT   = 2'd0;
   localparam logic [1:0] FUNC_AT     = 2'd1;
   localparam logic [1:0] FUNC_REWIND = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LL,
      ST_LH,
      ST_HL,
      ST_HH,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SUM_HOLD,
      SUM_LOAD,
      SUM_ADD_LO,
      SUM_ADD_HI
   } sum_op_type;

   typedef struct packed {
      sum_op_type              sum_op;
      logic [HALF_W-1:0]       mul_a;
      logic [HALF_W-1:0]       mul_b;
      logic [VAL_W-1:0]        load_val;
   } mac_ctrl_type;

   typedef struct packed {
      logic [TERM_W-1:0]                 terms;
      logic [VAL_W-1:0]                  mask;
      logic [MAX_TERMS-1:0][VAL_W-1:0]   coef;
   } cfg_type;

   // low value_bits bits set; a width of 63 gives all ones
   function automatic logic [VAL_W-1:0] width_mask(input logic [VBITS_W-1:0] vb);
      logic [VAL_W-1:0] m;
      for (int j = 0; j < VAL_W; j++) begin
         m[j] = (VBITS_W'(j) < vb);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

### src/kwise_polynomial_hash_generator.sv
// k-wise independent polynomial hash: value = sum of coef_i * x^i over term_count
// coefficients, modulo 2^value_bits. func 0 evaluates at the internal position
// and advances it, func 1 evaluates at req_index, func 2 rewinds the position
// without a result word, func 3 is ignored. Evaluation runs Horner steps on one
// shared 32x32 multiplier: each step runs through the states LL, LH, HL and HH
// (three partial products and the closing add). With k = min(term_count, 6),
// k-1 steps run, none for a count of zero or one; the result word is registered
// from ST_DONE, and the block then returns to idle to take the next request. A
// rewind or an ignored word is handled in idle and leaves the block there.
// The block takes one request at a time; a finished word sits in the output
// register while the next request is accepted, and if that word is still unread
// when the next evaluation ends, the block holds its result until the output frees.
// Registers are written through the csr port (0 value_bits, 1 term_count,
// 2..7 coef_0..coef_5); the user must write them only while idle, the block itself does not enforce this.
`default_nettype none
module kwise_polynomial_hash_generator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request words
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_func,
   input  wire logic [63:0]                   req_index,
   // result words
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [kph_pkg::VAL_W-1:0]          rsp_value,
   // register writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [kph_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [kph_pkg::CSR_DATA_W-1:0] csr_data
);
   import kph_pkg::*;

`include "kwise_polynomial_hash_generator_assert.svh"

   logic [VBITS_W-1:0]               value_bits_ff, value_bits_in;
   logic [TERM_W-1:0]                term_count_ff, term_count_in;
   logic [MAX_TERMS-1:0][VAL_W-1:0]  coef_ff, coef_in;
   logic [CSR_IDX_W-1:0]             coef_sel;
   cfg_type                          cfg;
   logic                             req_take;
   logic                             req_eval;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign coef_sel  = csr_index - REG_COEF_FIRST;

   always_comb begin
      value_bits_in = value_bits_ff;
      term_count_in = term_count_ff;
      coef_in       = coef_ff;
      if (csr_valid) begin
         if (csr_index == REG_VALUE_BITS) begin
            value_bits_in = csr_data[VBITS_W-1:0];
         end else if (csr_index == REG_TERM_COUNT) begin
            term_count_in = csr_data[TERM_W-1:0];
         end else if (csr_index >= REG_COEF_FIRST && csr_index <= REG_COEF_LAST) begin
            coef_in[coef_sel[TERM_W-1:0]] = csr_data[VAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_bits_ff <= VBITS_W'(32);
         term_count_ff <= TERM_W'(2);
         coef_ff       <= '0;
      end else begin
         value_bits_ff <= value_bits_in;
         term_count_ff <= term_count_in;
         coef_ff       <= coef_in;
      end
   end

   // term count saturates at the number of coefficient registers
   assign cfg.terms = (term_count_ff > TERM_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS)
                                                           : term_count_ff;
   assign cfg.mask  = width_mask(value_bits_ff);
   assign cfg.coef  = coef_ff;

   kph_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_index (req_index),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

   // request taken this cycle, and whether it asks for an evaluation
   assign req_take = req_valid && req_ready;
   assign req_eval = (req_func == FUNC_NEXT) || (req_func == FUNC_AT);

   // an evaluating request leaves idle, so the block is busy in the cycle after it is taken
   `KPH_ASSERT_NEXT(a_eval_busy, req_take && req_eval, !req_ready, "evaluation did not leave idle")
   // rewind and the unused kind finish in the cycle they are taken
   `KPH_ASSERT_NEXT(a_rewind_idle, req_take && !req_eval, req_ready, "non-evaluating left idle")
   // a new result word only comes out of a busy cycle
   `KPH_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready), "result without evaluation")

endmodule
`default_nettype wire

### src/kph_mac.sv
`default_nettype none
module kph_mac (
   input  wire logic                  clock,
   input  wire kph_pkg::mac_ctrl_type ctrl,
   output logic [kph_pkg::VAL_W-1:0]  sum
);
   import kph_pkg::*;

   logic [2*HALF_W-1:0] prod_ff;
   logic [2*HALF_W-1:0] prod_in;
   logic [VAL_W-1:0]    sum_ff;
   logic [VAL_W-1:0]    sum_in;

   // one 32x32 partial product per cycle
   assign prod_in = ctrl.mul_a * ctrl.mul_b;

   always_comb begin
      case (ctrl.sum_op)
         SUM_LOAD:   sum_in = ctrl.load_val;
         SUM_ADD_LO: sum_in = sum_ff + prod_ff[VAL_W-1:0];
         SUM_ADD_HI: sum_in = sum_ff + {prod_ff[VAL_W-HALF_W-1:0], {HALF_W{1'b0}}};
         default:    sum_in = sum_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign sum = sum_ff;

endmodule
`default_nettype wire

### src/kph_seq.sv
`default_nettype none
module kph_seq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire kph_pkg::cfg_type         cfg,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_func,
   input  wire logic [63:0]              req_index,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [kph_pkg::VAL_W-1:0]     rsp_value
);
   import kph_pkg::*;

   state_type           state_ff, state_in;
   logic [TERM_W-1:0]   rem_ff, rem_in;
   logic [VAL_W-1:0]    x_ff, x_in;
   logic [VAL_W-1:0]    acc_ff, acc_in;
   logic [VAL_W-1:0]    position_ff, position_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   mac_ctrl_type        ctrl;
   logic [VAL_W-1:0]    sum;
   logic [TERM_W-1:0]   coef_idx;
   logic [VAL_W-1:0]    pos_masked;

   kph_mac u_mac (
      .clock (clock),
      .ctrl  (ctrl),
      .sum   (sum)
   );

   assign coef_idx   = rem_ff - TERM_W'(1);
   assign pos_masked = position_ff & cfg.mask;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      position_in  = position_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      req_ready    = 1'b0;
      ctrl.sum_op   = SUM_HOLD;
      ctrl.mul_a    = '0;
      ctrl.mul_b    = '0;
      ctrl.load_val = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func)
                  FUNC_NEXT, FUNC_AT: begin
                     if (req_func == FUNC_NEXT) begin
                        x_in        = pos_masked;
                        position_in = (pos_masked + VAL_W'(1)) & cfg.mask;
                     end else begin
                        x_in = req_index[VAL_W-1:0] & cfg.mask;
                     end
                     // horner start: highest coefficient, or empty sum
                     ctrl.sum_op = SUM_LOAD;
                     if (cfg.terms == '0) begin
                        rem_in   = '0;
                        state_in = ST_DONE;
                     end else begin
                        ctrl.load_val = cfg.coef[cfg.terms - TERM_W'(1)];
                        rem_in        = cfg.terms - TERM_W'(1);
                        state_in      = (cfg.terms == TERM_W'(1)) ? ST_DONE : ST_LL;
                     end
                  end
                  FUNC_REWIND: position_in = '0;
                  default: ;
               endcase
            end
         end
         ST_LL: begin
            // acc low x low, sum restarts at the next coefficient
            acc_in        = sum;
            ctrl.mul_a    = sum[HALF_W-1:0];
            ctrl.mul_b    = x_ff[HALF_W-1:0];
            ctrl.sum_op   = SUM_LOAD;
            ctrl.load_val = cfg.coef[coef_idx];
            state_in      = ST_LH;
         end
         ST_LH: begin
            ctrl.mul_a  = acc_ff[HALF_W-1:0];
            ctrl.mul_b  = {1'b0, x_ff[VAL_W-1:HALF_W]};
            ctrl.sum_op = SUM_ADD_LO;
            state_in    = ST_HL;
         end
         ST_HL: begin
            ctrl.mul_a  = {1'b0, acc_ff[VAL_W-1:HALF_W]};
            ctrl.mul_b  = x_ff[HALF_W-1:0];
            ctrl.sum_op = SUM_ADD_HI;
            state_in    = ST_HH;
         end
         ST_HH: begin
            ctrl.sum_op = SUM_ADD_HI;
            rem_in      = coef_idx;
            state_in    = (coef_idx == '0) ? ST_DONE : ST_LL;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sum & cfg.mask;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_ff       <= '0;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         position_ff  <= position_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import kph_pkg::*;

   // kind 3 has no name in the package; it must be ignored by the block
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // an index past the coefficient bank, writes to it go nowhere
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 4'd15;
   // drain wait: longest evaluation with k = MAX_TERMS, plus margin
   localparam int DRAIN_CYCLES = 4 * (MAX_TERMS - 1) + 2 + 8;
   // upper bound on cycles spent waiting for outstanding words
   localparam int SETTLE_LIMIT = 5000;
   localparam int RANDOM_PHASES = 40;
   localparam int WORDS_PER_PHASE = 46;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_func;
   logic [63:0]           req_index;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [VAL_W-1:0]      rsp_value;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // shadow copy of the register file and the position counter
   logic [5:0]            cfg_value_bits;
   logic [2:0]            cfg_term_count;
   logic [VAL_W-1:0]      cfg_coef [MAX_TERMS];
   logic [VAL_W-1:0]      hash_position;

   // hash values still owed by the block, oldest first
   logic [VAL_W-1:0]      expected_values [$];
   logic [VAL_W-1:0]      head_value;
   int                    error_count;
   // when clear, neither side inserts gaps or stalls
   bit                    idling_on;

   kwise_polynomial_hash_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_index (req_index),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // low value_bits bits set; zero width gives an all-zero mask
   function automatic logic [63:0] value_mask();
      return (64'd1 << cfg_value_bits) - 64'd1;
   endfunction

   // horner-free straight sum: coef_i * x^i, every partial masked to the width
   function automatic logic [VAL_W-1:0] hash_at(input logic [63:0] x);
      logic [63:0] m;
      logic [63:0] acc;
      logic [63:0] pw;
      logic [63:0] xm;
      int          n;
      m   = value_mask();
      // term counts above the bank size saturate
      n   = (cfg_term_count > MAX_TERMS) ? MAX_TERMS : int'(cfg_term_count);
      xm  = x & m;
      acc = 64'd0;
      pw  = 64'd1 & m;
      for (int i = 0; i < n; i++) begin
         acc = (acc + (({1'b0, cfg_coef[i]} & m) * pw)) & m;
         pw  = (pw * xm) & m;
      end
      return acc[VAL_W-1:0];
   endfunction

   // called once per accepted request word
   function automatic void predict_word(input logic [1:0] func, input logic [63:0] index);
      logic [63:0] m;
      logic [63:0] pos;
      m = value_mask();
      case (func)
         FUNC_NEXT: begin
            // the counter is masked to the width in force now, not the old one
            pos = {1'b0, hash_position} & m;
            expected_values.push_back(hash_at(pos));
            hash_position = VAL_W'((pos + 64'd1) & m);
         end
         FUNC_AT: begin
            expected_values.push_back(hash_at(index));
         end
         FUNC_REWIND: begin
            hash_position = '0;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [63:0] data);
      if (idx == REG_VALUE_BITS) begin
         cfg_value_bits = data[5:0];
      end else if (idx == REG_TERM_COUNT) begin
         cfg_term_count = data[2:0];
      end else if (idx >= REG_COEF_FIRST && idx <= REG_COEF_LAST) begin
         cfg_coef[int'(idx - REG_COEF_FIRST)] = data[VAL_W-1:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // result checking and receiver back-pressure
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            $error("value: expected nothing, got %h", rsp_value);
            error_count++;
         end else begin
            head_value = expected_values.pop_front();
            if (rsp_value !== head_value) begin
               $error("value mismatch: expected %h, got %h", head_value, rsp_value);
               error_count++;
            end
         end
      end
   end

   // before each result word ready may drop while idling_on is set, then stays up until a word is valid
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = idling_on ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------

   // one request word; valid stays up between back-to-back words
   task automatic send_word(input logic [1:0] func, input logic [63:0] index);
      int gap;
      gap = idling_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func  = func;
      req_index = index;
      do @(posedge clock); while (!req_ready);
      predict_word(func, index);
   endtask

   // register write; only called once the block has gone quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // sender holds off until every owed word has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
   endtask

   // wait for all owed words, reporting any that never return, then idle for a drain margin
   task automatic settle_block();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_values.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_values.size() != 0) begin
         $error("value: %0d words expected, never returned (next expected %h)",
                expected_values.size(), expected_values[0]);
         error_count++;
         expected_values.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] random_wide();
      return {$urandom, $urandom};
   endfunction

   // biased towards the edges of the index range
   function automatic logic [63:0] random_index();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return '0;
         2: return 64'($urandom_range(0, 15));
         3: return 64'h8000_0000_0000_0000;
         default: return random_wide();
      endcase
   endfunction

   function automatic logic [63:0] random_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'd1;
         default: return random_wide();
      endcase
   endfunction

   function automatic logic [5:0] random_value_bits();
      case ($urandom_range(0, 7))
         0: return 6'd0;
         1: return 6'd1;
         2: return 6'd63;
         3: return 6'd62;
         4: return 6'd32;
         default: return 6'($urandom_range(0, 63));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset values: 32-bit width, two terms, all coefficients zero
   task automatic test_reset_state();
      send_word(FUNC_NEXT, random_wide());
      send_word(FUNC_AT, '1);
      send_word(FUNC_UNUSED, random_wide());
      send_word(FUNC_REWIND, random_wide());
      send_word(FUNC_NEXT, '0);
   endtask

   // widest modulus, full bank, coefficients with the top data bit set
   task automatic test_full_width();
      settle_block();
      // upper data bits are junk that the register must drop
      write_reg(REG_VALUE_BITS, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_TERM_COUNT, 64'hFFFF_FFFF_FFFF_FFFE);
      write_reg(REG_COEF_FIRST, '1);
      write_reg(REG_COEF_FIRST + 4'd1, 64'h8000_0000_0000_0001);
      for (int i = 2; i < MAX_TERMS; i++) begin
         write_reg(REG_COEF_FIRST + CSR_IDX_W'(i), random_wide());
      end
      send_word(FUNC_AT, '0);
      send_word(FUNC_AT, '1);
      send_word(FUNC_AT, 64'h8000_0000_0000_0000);
      send_word(FUNC_AT, 64'h7FFF_FFFF_FFFF_FFFF);
      send_word(FUNC_NEXT, '1);
      send_word(FUNC_NEXT, '0);
      send_word(FUNC_NEXT, random_wide());
   endtask

   // counter wrap, narrowing the width under a live counter, zero width, no terms
   task automatic test_width_edges();
      settle_block();
      write_reg(REG_VALUE_BITS, 64'd2);
      // seven terms saturates to the bank size
      write_reg(REG_TERM_COUNT, 64'd7);
      write_reg(REG_UNUSED, '1);
      repeat (5) send_word(FUNC_NEXT, random_wide());
      settle_block();
      write_reg(REG_VALUE_BITS, 64'd1);
      repeat (2) send_word(FUNC_NEXT, random_wide());
      settle_block();
      write_reg(REG_VALUE_BITS, 64'd0);
      send_word(FUNC_NEXT, random_wide());
      send_word(FUNC_AT, '1);
      settle_block();
      write_reg(REG_VALUE_BITS, 64'd63);
      write_reg(REG_TERM_COUNT, 64'd0);
      send_word(FUNC_AT, random_wide());
      send_word(FUNC_NEXT, random_wide());
   endtask

   // random settings per phase, random words within a phase
   task automatic test_random_traffic();
      int          pick;
      logic [1:0]  func;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_block();
         // roughly one phase in four runs flat out on both sides
         idling_on = ($urandom_range(0, 3) != 0);
         write_reg(REG_VALUE_BITS, {random_wide()} & ~64'h3F | 64'(random_value_bits()));
         write_reg(REG_TERM_COUNT, random_wide());
         for (int i = 0; i < MAX_TERMS; i++) begin
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
               write_reg(REG_COEF_FIRST + CSR_IDX_W'(i), random_coef());
            end
         end
         if ($urandom_range(0, 7) == 0) begin
            write_reg(CSR_IDX_W'($urandom_range(8, 15)), random_wide());
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               func = FUNC_NEXT;
            end else if (pick < 8) begin
               func = FUNC_AT;
            end else if (pick == 8) begin
               func = FUNC_REWIND;
            end else begin
               func = FUNC_UNUSED;
            end
            // hold the sender back until the output side has emptied
            if ((phase == 3 && n == 20) || $urandom_range(0, 63) == 0) begin
               drain_results();
            end
            send_word(func, random_index());
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_NEXT;
      req_index      = '0;
      csr_valid      = 1'b0;
      csr_index      = REG_VALUE_BITS;
      csr_data       = '0;
      error_count    = 0;
      idling_on      = 1'b1;
      // shadow state mirrors the block's reset values
      cfg_value_bits = 6'd32;
      cfg_term_count = 3'd2;
      for (int i = 0; i < MAX_TERMS; i++) begin
         cfg_coef[i] = '0;
      end
      hash_position  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_full_width();
      test_width_edges();
      test_random_traffic();
      settle_block();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
